/* rtl/core/dpd_pkg.sv */
// shared types and constants for the digitizer packet deframer
`default_nettype none
package dpd_pkg;

    localparam int WORD_W = 16;
    localparam int IDX_W  = 13;

    localparam logic [WORD_W-1:0] MARKER_WORD   = 16'hAAAA;
    localparam logic [WORD_W-1:0] OFFSET_RESET  = 16'd512;
    localparam logic [IDX_W-1:0]  IDX_MAX       = 13'd8191;
    localparam logic [IDX_W-1:0]  MIN_LEN       = 13'd16;
    localparam logic [IDX_W-1:0]  LEN_EXTRA     = 13'd2;

    // word positions inside a packet
    localparam logic [IDX_W-1:0] POS_MARK_A  = 13'd0;
    localparam logic [IDX_W-1:0] POS_MARK_B  = 13'd1;
    localparam logic [IDX_W-1:0] POS_LENGTH  = 13'd2;
    localparam logic [IDX_W-1:0] POS_CHAN    = 13'd3;
    localparam logic [IDX_W-1:0] POS_LED_MID = 13'd4;
    localparam logic [IDX_W-1:0] POS_LED_LO  = 13'd5;
    localparam logic [IDX_W-1:0] POS_EN_LO   = 13'd6;
    localparam logic [IDX_W-1:0] POS_LED_HI  = 13'd7;
    localparam logic [IDX_W-1:0] POS_CFD_LO  = 13'd8;
    localparam logic [IDX_W-1:0] POS_EN_HI   = 13'd9;
    localparam logic [IDX_W-1:0] POS_CFD_HI  = 13'd10;
    localparam logic [IDX_W-1:0] POS_CFD_MID = 13'd11;
    localparam logic [IDX_W-1:0] POS_P1_LO   = 13'd12;
    localparam logic [IDX_W-1:0] POS_P1_HI   = 13'd13;
    localparam logic [IDX_W-1:0] POS_P2_LO   = 13'd14;
    localparam logic [IDX_W-1:0] POS_HEADER  = 13'd15;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_MARKER = 2'd2,
        KIND_LENGTH = 2'd3
    } t_kind;

    typedef struct packed {
        logic [4:0]  board_num;
        logic [3:0]  channel;
        logic [11:0] module_res;
        logic [47:0] led_stamp;
        logic [23:0] energy;
        logic        energy_negative;
        logic        pile_up;
        logic [47:0] cfd_stamp;
        logic [31:0] cfd_point_one;
        logic [31:0] cfd_point_two;
    } t_header;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] word;
        t_header           hdr;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage
`default_nettype wire

/* rtl/core/dpd_in_if.sv */
// input word channel
`default_nettype none
interface dpd_in_if;
    logic                    valid;
    logic                    ready;
    logic [dpd_pkg::WORD_W-1:0] data_word;
    logic                    first_word;
    logic                    last_word;

    modport source (output valid, output data_word, output first_word, output last_word,
                    input ready);
    modport sink (input valid, input data_word, input first_word, input last_word,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/dpd_cfg_if.sv */
// configuration write channel
`default_nettype none
interface dpd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dpd_pkg::WORD_W-1:0] trace_offset;

    modport source (output valid, output trace_offset, input ready);
    modport sink (input valid, input trace_offset, output ready);
endinterface
`default_nettype wire

/* rtl/core/dpd_out_if.sv */
// result channel
`default_nettype none
interface dpd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [4:0]         board_num;
    logic [3:0]         channel;
    logic [11:0]        module_res;
    logic [47:0]        led_stamp;
    logic [23:0]        energy;
    logic               energy_negative;
    logic               pile_up;
    logic [47:0]        cfd_stamp;
    logic [31:0]        cfd_point_one;
    logic [31:0]        cfd_point_two;
    logic signed [15:0] sample;

    modport source (output valid, output result_kind, output board_num, output channel,
                    output module_res, output led_stamp, output energy,
                    output energy_negative, output pile_up, output cfd_stamp,
                    output cfd_point_one, output cfd_point_two, output sample,
                    input ready);
    modport sink (input valid, input result_kind, input board_num, input channel,
                  input module_res, input led_stamp, input energy,
                  input energy_negative, input pile_up, input cfd_stamp,
                  input cfd_point_one, input cfd_point_two, input sample,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/dpd_front.sv */
// front end: word position tracking, field capture and result classification
`default_nettype none
module dpd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dpd_in_if.sink              i_data,
    input  wire logic           i_q_full,
    output dpd_pkg::t_push      o_push
);
    import dpd_pkg::*;

    logic [IDX_W-1:0]  r_word_index, n_word_index;
    logic [IDX_W-1:0]  r_declared,   n_declared;
    logic              r_failed,     n_failed;
    logic [4:0]        r_board,      n_board;
    logic [3:0]        r_channel,    n_channel;
    logic [11:0]       r_module,     n_module;
    logic [47:0]       r_led,        n_led;
    logic [25:0]       r_energy,     n_energy;
    logic [47:0]       r_cfd,        n_cfd;
    logic [31:0]       r_cfd_one,    n_cfd_one;
    logic [15:0]       r_cfd_two_lo, n_cfd_two_lo;

    logic              accept;
    logic [WORD_W-1:0] w;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  decl;
    logic              fail_now;
    logic              emit;
    t_kind             kind;

    assign i_data.ready = !i_q_full;
    assign accept       = i_data.valid && i_data.ready;
    assign w            = i_data.data_word;
    assign last         = i_data.last_word;

    always_comb begin
        idx          = i_data.first_word ? '0 : r_word_index;
        fail_now     = i_data.first_word ? 1'b0 : r_failed;
        decl         = r_declared;
        emit         = 1'b0;
        kind         = KIND_HEADER;
        n_declared   = r_declared;
        n_board      = r_board;
        n_channel    = r_channel;
        n_module     = r_module;
        n_led        = r_led;
        n_energy     = r_energy;
        n_cfd        = r_cfd;
        n_cfd_one    = r_cfd_one;
        n_cfd_two_lo = r_cfd_two_lo;

        if (fail_now) begin
            // rest of a failed packet is dropped
        end else if (idx == POS_MARK_A) begin
            n_declared = {{(IDX_W-1){1'b0}}, (w != MARKER_WORD)};
            if (last) begin
                emit = 1'b1;
                kind = KIND_MARKER;
            end
        end else if (idx == POS_MARK_B) begin
            if (r_declared != '0 || w != MARKER_WORD) begin
                emit     = 1'b1;
                kind     = KIND_MARKER;
                fail_now = 1'b1;
            end else if (last) begin
                emit = 1'b1;
                kind = KIND_LENGTH;
            end
        end else begin
            if (idx == POS_LENGTH) begin
                decl       = {1'b0, w[10:0], 1'b0} + LEN_EXTRA;
                n_declared = decl;
                n_board    = w[15:11];
            end else if (idx >= r_declared) begin
                emit     = 1'b1;
                kind     = KIND_LENGTH;
                fail_now = 1'b1;
            end
            if (!fail_now) begin
                case (idx)
                    POS_CHAN: begin
                        n_channel = w[3:0];
                        n_module  = w[15:4];
                        n_led     = '0;
                        n_energy  = '0;
                        n_cfd     = '0;
                    end
                    POS_LED_MID: n_led[31:16]   = w;
                    POS_LED_LO:  n_led[15:0]    = w;
                    POS_EN_LO:   n_energy[15:0] = w;
                    POS_LED_HI:  n_led[47:32]   = w;
                    POS_CFD_LO:  n_cfd[15:0]    = w;
                    POS_EN_HI: begin
                        n_energy[23:16] = w[7:0];
                        n_energy[24]    = w[8];
                        n_energy[25]    = w[15];
                    end
                    POS_CFD_HI:  n_cfd[47:32]  = w;
                    POS_CFD_MID: n_cfd[31:16]  = w;
                    POS_P1_LO:   n_cfd_one     = {16'b0, w};
                    POS_P1_HI:   n_cfd_one[31:16] = w;
                    POS_P2_LO:   n_cfd_two_lo  = w;
                    POS_HEADER: begin
                        emit = 1'b1;
                        kind = KIND_HEADER;
                    end
                    default: begin
                        if (idx >= MIN_LEN) begin
                            emit = 1'b1;
                            kind = KIND_SAMPLE;
                        end
                    end
                endcase
                // short or mismatched packet overrides the word's own result
                if (last && (({1'b0, idx} + 14'd1) != {1'b0, decl} || decl < MIN_LEN)) begin
                    emit = 1'b1;
                    kind = KIND_LENGTH;
                end
            end
        end

        n_failed = last ? 1'b0 : fail_now;
        if (last) begin
            n_word_index = '0;
        end else if (idx < IDX_MAX) begin
            n_word_index = idx + 1'b1;
        end else begin
            n_word_index = idx;
        end

        o_push.valid                   = accept && emit;
        o_push.cmd.kind                = kind;
        o_push.cmd.word                = w;
        o_push.cmd.hdr.board_num       = r_board;
        o_push.cmd.hdr.channel         = r_channel;
        o_push.cmd.hdr.module_res      = r_module;
        o_push.cmd.hdr.led_stamp       = r_led;
        o_push.cmd.hdr.energy          = r_energy[23:0];
        o_push.cmd.hdr.energy_negative = r_energy[24];
        o_push.cmd.hdr.pile_up         = r_energy[25];
        o_push.cmd.hdr.cfd_stamp       = r_cfd;
        o_push.cmd.hdr.cfd_point_one   = r_cfd_one;
        o_push.cmd.hdr.cfd_point_two   = {w, r_cfd_two_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_index <= '0;
            r_declared   <= '0;
            r_failed     <= 1'b0;
        end else if (accept) begin
            r_word_index <= n_word_index;
            r_declared   <= n_declared;
            r_failed     <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_board      <= n_board;
            r_channel    <= n_channel;
            r_module     <= n_module;
            r_led        <= n_led;
            r_energy     <= n_energy;
            r_cfd        <= n_cfd;
            r_cfd_one    <= n_cfd_one;
            r_cfd_two_lo <= n_cfd_two_lo;
        end
    end

`ifndef NO_ASSERTIONS
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid && o_push.cmd.kind == KIND_HEADER |-> idx == POS_HEADER)
        else $error("header transaction queued away from its word position");

    a_failed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> r_word_index >= POS_LENGTH)
        else $error("packet marked failed before the length word");
`endif

endmodule
`default_nettype wire

/* rtl/core/dpd_queue.sv */
// short result queue between front end and output stage
`default_nettype none
module dpd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dpd_pkg::t_push i_push,
    input  wire logic           i_pop,
    output logic                o_full,
    output dpd_pkg::t_head      o_head
);
    import dpd_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              do_pop;

    assign o_full       = (r_count == QCNT_W'(QDEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("result queue holds more than its depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queued transaction lost");
`endif

endmodule
`default_nettype wire

/* rtl/core/dpd_back.sv */
// output stage: trace sample arithmetic, field masking and result register
`default_nettype none
module dpd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    dpd_cfg_if.sink             i_cfg,
    input  wire dpd_pkg::t_head i_head,
    output logic                o_pop,
    dpd_out_if.source           o_result
);
    import dpd_pkg::*;

    logic [WORD_W-1:0] r_offset;
    logic              r_valid;
    t_kind             r_kind;
    t_header           r_hdr;
    logic [WORD_W-1:0] r_sample;
    t_header           n_hdr;
    logic [WORD_W-1:0] n_sample;

    assign i_cfg.ready = 1'b1;
    assign o_pop       = i_head.valid && (!r_valid || o_result.ready);

    always_comb begin
        n_hdr    = (i_head.cmd.kind == KIND_HEADER) ? i_head.cmd.hdr : '0;
        // negated word plus offset, wraps to 16 bits
        n_sample = (i_head.cmd.kind == KIND_SAMPLE) ? r_offset - i_head.cmd.word : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_offset <= OFFSET_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_offset <= i_cfg.trace_offset;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_head.cmd.kind;
            r_hdr    <= n_hdr;
            r_sample <= n_sample;
        end
    end

    assign o_result.valid           = r_valid;
    assign o_result.result_kind     = r_kind;
    assign o_result.board_num       = r_hdr.board_num;
    assign o_result.channel         = r_hdr.channel;
    assign o_result.module_res      = r_hdr.module_res;
    assign o_result.led_stamp       = r_hdr.led_stamp;
    assign o_result.energy          = r_hdr.energy;
    assign o_result.energy_negative = r_hdr.energy_negative;
    assign o_result.pile_up         = r_hdr.pile_up;
    assign o_result.cfd_stamp       = r_hdr.cfd_stamp;
    assign o_result.cfd_point_one   = r_hdr.cfd_point_one;
    assign o_result.cfd_point_two   = r_hdr.cfd_point_two;
    assign o_result.sample          = $signed(r_sample);

endmodule
`default_nettype wire

/* rtl/core/digitizer_packet_deframer.sv */
// result path: the result of an accepted word is written to the result queue, then to the output register
// throughput: one word per cycle; the front end stalls only when the two-entry
//   result queue is full, which happens only while the result side holds off ready
// reset: word position, packet state, queue and output register clear, trace
//   offset returns to 512; no clearing pass, the block takes words right after reset
`default_nettype none
module digitizer_packet_deframer (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpd_in_if.sink    i_data,
    dpd_cfg_if.sink   i_cfg,
    dpd_out_if.source o_result
);
    import dpd_pkg::*;

    t_push q_push;
    t_head q_head;
    logic  q_full;
    logic  q_pop;

    dpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_push   (q_push)
    );

    dpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    dpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_head   (q_head),
        .o_pop    (q_pop),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

/* sim/dpd_deframer_checker.sv */
// checker: predicts deframer results from observed transactions and compares them
module dpd_deframer_checker
    import dpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpd_in_if         i_data,
    dpd_cfg_if        i_cfg,
    dpd_out_if        i_result,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        t_kind              kind;
        t_header            hdr;
        logic signed [15:0] smp;
    } t_deframe_result;

    t_deframe_result   result_q[$];
    int                mismatches = 0;

    logic [WORD_W-1:0] trace_offset;
    logic [IDX_W-1:0]  word_pos;
    logic [IDX_W-1:0]  declared_len;
    logic              pkt_dead;
    logic [4:0]        board;
    logic [3:0]        chan;
    logic [11:0]       module_num;
    logic [47:0]       led_acc;
    logic [25:0]       energy_acc;
    logic [47:0]       cfd_acc;
    logic [31:0]       point_one;
    logic [15:0]       point_two_low;

    function automatic string describe(t_deframe_result x);
        return {$sformatf("kind %0d board %0d chan %0d module %0d led %h energy %h",
                          x.kind, x.hdr.board_num, x.hdr.channel, x.hdr.module_res,
                          x.hdr.led_stamp, x.hdr.energy),
                $sformatf(" neg %b pile %b cfd %h p1 %h p2 %h sample %0d",
                          x.hdr.energy_negative, x.hdr.pile_up, x.hdr.cfd_stamp,
                          x.hdr.cfd_point_one, x.hdr.cfd_point_two, x.smp)};
    endfunction

    // one accepted word: update packet state, queue the result it causes if any
    task automatic deframe_word(input logic [15:0] w, input logic first, input logic last);
        t_deframe_result r;
        logic            emit;
        r = '0;
        emit = 1'b0;
        if (first) begin
            word_pos = '0;
            pkt_dead = 1'b0;
        end
        if (pkt_dead) begin
            // rest of a failed packet is dropped
        end else if (word_pos == POS_MARK_A) begin
            declared_len = (w != MARKER_WORD) ? 13'd1 : 13'd0;
            if (last) begin
                r.kind = KIND_MARKER;
                emit = 1'b1;
            end
        end else if (word_pos == POS_MARK_B) begin
            if (declared_len != 0 || w != MARKER_WORD) begin
                r.kind = KIND_MARKER;
                emit = 1'b1;
                pkt_dead = 1'b1;
            end else if (last) begin
                r.kind = KIND_LENGTH;
                emit = 1'b1;
            end
        end else begin
            if (word_pos == POS_LENGTH) begin
                declared_len = {1'b0, w[10:0], 1'b0} + LEN_EXTRA;
                board = w[15:11];
            end else if (word_pos >= declared_len) begin
                r.kind = KIND_LENGTH;
                emit = 1'b1;
                pkt_dead = 1'b1;
            end
            if (!pkt_dead) begin
                case (word_pos)
                    POS_CHAN: begin
                        chan = w[3:0];
                        module_num = w[15:4];
                        led_acc = '0;
                        energy_acc = '0;
                        cfd_acc = '0;
                    end
                    POS_LED_MID: led_acc = led_acc | (48'(w) << 16);
                    POS_LED_LO:  led_acc = led_acc | 48'(w);
                    POS_EN_LO:   energy_acc = energy_acc | 26'(w);
                    POS_LED_HI:  led_acc = led_acc | (48'(w) << 32);
                    POS_CFD_LO:  cfd_acc = cfd_acc | 48'(w);
                    // energy high byte, sign in bit 8, pile-up in bit 15
                    POS_EN_HI:   energy_acc = energy_acc | {w[15], w[8], w[7:0], 16'h0000};
                    POS_CFD_HI:  cfd_acc = cfd_acc | (48'(w) << 32);
                    POS_CFD_MID: cfd_acc = cfd_acc | (48'(w) << 16);
                    POS_P1_LO:   point_one = 32'(w);
                    POS_P1_HI:   point_one = point_one | (32'(w) << 16);
                    POS_P2_LO:   point_two_low = w;
                    POS_HEADER: begin
                        r.kind = KIND_HEADER;
                        r.hdr.board_num = board;
                        r.hdr.channel = chan;
                        r.hdr.module_res = module_num;
                        r.hdr.led_stamp = led_acc;
                        r.hdr.energy = energy_acc[23:0];
                        r.hdr.energy_negative = energy_acc[24];
                        r.hdr.pile_up = energy_acc[25];
                        r.hdr.cfd_stamp = cfd_acc;
                        r.hdr.cfd_point_one = point_one;
                        r.hdr.cfd_point_two = {w, point_two_low};
                        emit = 1'b1;
                    end
                    default: begin
                        if (word_pos > POS_HEADER) begin
                            r.kind = KIND_SAMPLE;
                            r.smp = trace_offset - w;
                            emit = 1'b1;
                        end
                    end
                endcase
                // short or undersized packet overrides whatever this word produced
                if (last && (int'(word_pos) + 1 != int'(declared_len)
                             || declared_len < MIN_LEN)) begin
                    r = '0;
                    r.kind = KIND_LENGTH;
                    emit = 1'b1;
                end
            end
        end
        if (last) begin
            word_pos = '0;
            pkt_dead = 1'b0;
        end else if (word_pos < IDX_MAX) begin
            word_pos = word_pos + 1'b1;
        end
        if (emit) result_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_deframe_result want;
        t_deframe_result got;
        if (!i_rst_n) begin
            trace_offset = OFFSET_RESET;
            word_pos = '0;
            declared_len = '0;
            pkt_dead = 1'b0;
            board = '0;
            chan = '0;
            module_num = '0;
            led_acc = '0;
            energy_acc = '0;
            cfd_acc = '0;
            point_one = '0;
            point_two_low = '0;
            result_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) trace_offset = i_cfg.trace_offset;
            if (i_data.valid && i_data.ready)
                deframe_word(i_data.data_word, i_data.first_word, i_data.last_word);
            if (i_result.valid && i_result.ready) begin
                got.kind = t_kind'(i_result.result_kind);
                got.hdr.board_num = i_result.board_num;
                got.hdr.channel = i_result.channel;
                got.hdr.module_res = i_result.module_res;
                got.hdr.led_stamp = i_result.led_stamp;
                got.hdr.energy = i_result.energy;
                got.hdr.energy_negative = i_result.energy_negative;
                got.hdr.pile_up = i_result.pile_up;
                got.hdr.cfd_stamp = i_result.cfd_stamp;
                got.hdr.cfd_point_one = i_result.cfd_point_one;
                got.hdr.cfd_point_two = i_result.cfd_point_two;
                got.smp = i_result.sample;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction: %s", describe(got));
                end else begin
                    want = result_q.pop_front();
                    if (want.kind !== got.kind
                        || want.hdr.board_num !== got.hdr.board_num
                        || want.hdr.channel !== got.hdr.channel
                        || want.hdr.module_res !== got.hdr.module_res
                        || want.hdr.led_stamp !== got.hdr.led_stamp
                        || want.hdr.energy !== got.hdr.energy
                        || want.hdr.energy_negative !== got.hdr.energy_negative
                        || want.hdr.pile_up !== got.hdr.pile_up
                        || want.hdr.cfd_stamp !== got.hdr.cfd_stamp
                        || want.hdr.cfd_point_one !== got.hdr.cfd_point_one
                        || want.hdr.cfd_point_two !== got.hdr.cfd_point_two
                        || want.smp !== got.smp) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("expected %s", describe(want));
                            $display("  actual %s", describe(got));
                        end
                    end
                end
            end
        end
        o_pending <= result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* sim/tb_digitizer_packet_deframer.sv */
// testbench top: drives packet words and trace offset writes, reports the verdict
module tb_digitizer_packet_deframer;
    import dpd_pkg::*;

    localparam int RUN_LIMIT = 200000;

    // directed packet with extreme field values and two trace words
    localparam logic [15:0] EDGE_PACKET [18] = '{
        16'hAAAA, 16'hAAAA, 16'hF808, 16'hFFFF, 16'hFFFF, 16'h0000,
        16'hFFFF, 16'h8000, 16'h0001, 16'h81FF, 16'hFFFF, 16'h0000,
        16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF
    };

    typedef enum int {
        PKT_GOOD,
        PKT_BAD_MARK_A,
        PKT_BAD_MARK_B,
        PKT_SHORT,
        PKT_LONG,
        PKT_NO_FIRST,
        PKT_CUT,
        PKT_NOISE
    } t_pkt_form;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    int   src_idle_pct = 25;
    int   dst_idle_pct = 86;
    int   words_sent = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending_results;

    dpd_in_if  data_ch ();
    dpd_cfg_if cfg_ch ();
    dpd_out_if res_ch ();

    assign res_ch.ready = sink_ready;

    digitizer_packet_deframer u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_data   (data_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    dpd_deframer_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_data       (data_ch),
        .i_cfg        (cfg_ch),
        .i_result     (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        sink_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_word(input logic [15:0] w, input logic first, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            data_ch.valid <= 1'b0;
            @(posedge clk);
        end
        data_ch.valid <= 1'b1;
        data_ch.data_word <= w;
        data_ch.first_word <= first;
        data_ch.last_word <= last;
        @(posedge clk);
        while (!data_ch.ready) @(posedge clk);
    endtask

    // hold the sender until every expected result is out, then let the pipe settle
    task automatic wait_idle();
        data_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_offset(input logic [15:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.trace_offset <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_packet(input t_pkt_form form, input logic [10:0] len_field);
        logic [15:0] body[$];
        int          total;
        int          n_send;
        if (form == PKT_NOISE) begin
            repeat ($urandom_range(1, 6))
                send_word(16'($urandom_range(0, 65535)), ($urandom_range(0, 3) == 0),
                          ($urandom_range(0, 3) == 0));
            return;
        end
        total = 2 * int'(len_field) + 2;
        body.push_back(MARKER_WORD);
        body.push_back(MARKER_WORD);
        body.push_back({5'($urandom_range(0, 31)), len_field});
        while (body.size() < total) body.push_back(16'($urandom_range(0, 65535)));
        n_send = total;
        case (form)
            PKT_BAD_MARK_A: body[0] = body[0] ^ (16'd1 << $urandom_range(0, 15));
            PKT_BAD_MARK_B: body[1] = body[1] ^ (16'd1 << $urandom_range(0, 15));
            PKT_SHORT:      n_send = $urandom_range(1, total - 1);
            PKT_LONG: begin
                repeat ($urandom_range(1, 3)) body.push_back(16'($urandom_range(0, 65535)));
                n_send = body.size();
            end
            PKT_CUT:        n_send = $urandom_range(1, total - 1);
            default: ;
        endcase
        // a cut packet never sees its last word, the next first word restarts it
        for (int k = 0; k < n_send; k++)
            send_word(body[k], (k == 0) && (form != PKT_NO_FIRST),
                      (k == n_send - 1) && (form != PKT_CUT));
        words_sent += n_send;
    endtask

    task automatic run_phase(input int src_pct, input int dst_pct, input int n_words,
                             input bit with_longest);
        int          start_count;
        int          pick;
        t_pkt_form   form;
        logic [10:0] len_field;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        start_count = words_sent;
        if (with_longest) send_packet(PKT_GOOD, 11'h7FF);
        while (words_sent - start_count < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      form = PKT_GOOD;
            else if (pick < 66) form = PKT_BAD_MARK_A;
            else if (pick < 72) form = PKT_BAD_MARK_B;
            else if (pick < 78) form = PKT_SHORT;
            else if (pick < 84) form = PKT_LONG;
            else if (pick < 88) form = PKT_NO_FIRST;
            else if (pick < 92) form = PKT_CUT;
            else                form = PKT_NOISE;
            pick = $urandom_range(0, 99);
            if (pick < 8)       len_field = 11'($urandom_range(0, 6));
            else if (pick < 95) len_field = 11'($urandom_range(7, 12));
            else                len_field = 11'($urandom_range(13, 40));
            send_packet(form, len_field);
        end
    endtask

    initial begin
        data_ch.valid <= 1'b0;
        data_ch.data_word <= '0;
        data_ch.first_word <= 1'b0;
        data_ch.last_word <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.trace_offset <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 18; k++) send_word(EDGE_PACKET[k], k == 0, k == 17);
        // one-word packet with a bad first marker
        send_word(16'h5555, 1'b1, 1'b1);
        // good markers, then the packet ends
        send_word(MARKER_WORD, 1'b1, 1'b0);
        send_word(MARKER_WORD, 1'b0, 1'b1);
        // bad second marker, the closing word is dropped
        send_word(MARKER_WORD, 1'b1, 1'b0);
        send_word(16'h2AAA, 1'b0, 1'b0);
        send_word(MARKER_WORD, 1'b0, 1'b1);

        write_offset(16'hFFFF);
        run_phase(25, 86, 600, 1'b0);
        write_offset(16'h0000);
        run_phase(86, 25, 600, 1'b0);
        write_offset(16'($urandom_range(0, 65535)));
        run_phase(0, 0, 600, 1'b0);
        wait_idle();

        if (fail_count == 0 && pending_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dpd_pkg.sv
rtl/core/dpd_in_if.sv
rtl/core/dpd_cfg_if.sv
rtl/core/dpd_out_if.sv
rtl/core/dpd_front.sv
rtl/core/dpd_queue.sv
rtl/core/dpd_back.sv
rtl/core/digitizer_packet_deframer.sv
sim/dpd_deframer_checker.sv
sim/tb_digitizer_packet_deframer.sv
